### rtl/core/insertion_argsort_macros.svh
// Assertion macros for the insertion argsort block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef INSERTION_ARGSORT_MACROS_SVH
`define INSERTION_ARGSORT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define IA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("insertion_argsort: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define IA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("insertion_argsort: next-cycle check failed");

`endif

### rtl/core/ia_pkg.sv
// Shared types and constants of the insertion argsort block.
// No dependencies.
package ia_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int KEY_W     = 32;
	localparam int OPOS_W    = 6;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctrl_t;

	// Controller states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

### rtl/core/ia_cell.sv
// One cell of the sorting chain: holds one key and its arrival position.
// Depends on ia_pkg.
module ia_cell #(
	parameter int POS_W = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ia_pkg::cell_ctrl_t               ctrl,
	input  logic signed [ia_pkg::KEY_W-1:0]  new_key,
	input  logic [POS_W-1:0]                 new_pos,
	input  logic                             prev_valid,
	input  logic                             prev_gt,
	input  logic signed [ia_pkg::KEY_W-1:0]  prev_key,
	input  logic [POS_W-1:0]                 prev_pos,
	input  logic                             next_valid,
	input  logic signed [ia_pkg::KEY_W-1:0]  next_key,
	input  logic [POS_W-1:0]                 next_pos,
	output logic                             valid,
	output logic                             gt,
	output logic signed [ia_pkg::KEY_W-1:0]  key_out,
	output logic [POS_W-1:0]                 pos_out
);

	logic                            valid_q;
	logic signed [ia_pkg::KEY_W-1:0] key_q;
	logic [POS_W-1:0]                pos_q;
	logic                            take_prev;
	logic                            take_new;

	// Strict compare keeps equal keys in arrival order
	assign gt = valid_q && (key_q > new_key);

	// Move up when the lower neighbor moves up; take the new word at the boundary
	assign take_prev = prev_gt;
	assign take_new  = !prev_gt && (gt || (!valid_q && prev_valid));

	// Hold the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= next_valid;
		end else if (ctrl.insert) begin
			valid_q <= valid_q | take_prev | take_new;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= next_key;
			pos_q <= next_pos;
		end else if (ctrl.insert) begin
			if (take_prev) begin
				key_q <= prev_key;
				pos_q <= prev_pos;
			end else if (take_new) begin
				key_q <= new_key;
				pos_q <= new_pos;
			end
		end
	end

	assign valid   = valid_q;
	assign key_out = key_q;
	assign pos_out = pos_q;

endmodule

### rtl/core/insertion_argsort.sv
// Top level of the insertion argsort block: control, cell chain, result register.
// Depends on ia_pkg, ia_cell and insertion_argsort_macros.svh.
//
//  channel  | handshake                    | ports
//  ---------+------------------------------+---------------------------------------------
//  input    | start && !busy               | key, last_key
//  result   | result_strobe                | sorted_key, origin_position, last_result,
//           |                              | overflowed
//
// When a key is taken, every cell compares it with its own key and the greater ones shift
// up in the same cycle, so keys enter back to back while busy is low.
// After the word marked last, the chain shifts down one cell per cycle and busy stays
// high until the stored keys are drained; each result is registered and appears in the cycle after its shift.
// Reset empties the chain and clears the fill count and overflow flag; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "insertion_argsort_macros.svh"

module insertion_argsort #(
	parameter int DEPTH = ia_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [ia_pkg::KEY_W-1:0]     key,
	input  logic                                last_key,
	output logic                                result_strobe,
	output logic signed [ia_pkg::KEY_W-1:0]     sorted_key,
	output logic [ia_pkg::OPOS_W-1:0]           origin_position,
	output logic                                last_result,
	output logic                                overflowed
);

	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ia_pkg::state_t     state_q;
	ia_pkg::cell_ctrl_t ctrl;
	logic [CNT_W-1:0]   fill_q;
	logic               overflow_q;
	logic               accept;
	logic               full;

	logic                            cell_valid [DEPTH];
	logic                            cell_gt    [DEPTH];
	logic signed [ia_pkg::KEY_W-1:0] cell_key   [DEPTH];
	logic [POS_W-1:0]                cell_pos   [DEPTH];
	logic [DEPTH-1:0]                valid_vec;

	logic                            res_strobe_q;
	logic signed [ia_pkg::KEY_W-1:0] res_key_q;
	logic [POS_W-1:0]                res_pos_q;
	logic                            res_last_q;
	logic                            res_ovf_q;

	assign busy   = (state_q == ia_pkg::ST_DRAIN);
	assign accept = start && !busy;
	assign full   = (fill_q == CNT_W'(DEPTH));

	// Broadcast the chain command
	assign ctrl.insert = accept && !full;
	assign ctrl.shift  = busy;

	// Build the chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                            p_valid;
		logic                            p_gt;
		logic signed [ia_pkg::KEY_W-1:0] p_key;
		logic [POS_W-1:0]                p_pos;
		logic                            n_valid;
		logic signed [ia_pkg::KEY_W-1:0] n_key;
		logic [POS_W-1:0]                n_pos;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_gt    = 1'b0;
			assign p_key   = key;
			assign p_pos   = fill_q[POS_W-1:0];
		end else begin : g_body
			assign p_valid = cell_valid[i-1];
			assign p_gt    = cell_gt[i-1];
			assign p_key   = cell_key[i-1];
			assign p_pos   = cell_pos[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = cell_key[i];
			assign n_pos   = cell_pos[i];
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_key   = cell_key[i+1];
			assign n_pos   = cell_pos[i+1];
		end

		ia_cell #(.POS_W(POS_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (key),
			.new_pos    (fill_q[POS_W-1:0]),
			.prev_valid (p_valid),
			.prev_gt    (p_gt),
			.prev_key   (p_key),
			.prev_pos   (p_pos),
			.next_valid (n_valid),
			.next_key   (n_key),
			.next_pos   (n_pos),
			.valid      (cell_valid[i]),
			.gt         (cell_gt[i]),
			.key_out    (cell_key[i]),
			.pos_out    (cell_pos[i])
		);

		assign valid_vec[i] = cell_valid[i];
	end

	// Sequence fill and drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ia_pkg::ST_IDLE;
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				ia_pkg::ST_IDLE: begin
					if (accept) begin
						if (full) begin
							overflow_q <= 1'b1;
						end else begin
							fill_q <= fill_q + {{(CNT_W-1){1'b0}}, 1'b1};
						end
						if (last_key) begin
							state_q <= ia_pkg::ST_DRAIN;
						end
					end
				end
				ia_pkg::ST_DRAIN: begin
					if (!cell_valid[1]) begin
						state_q    <= ia_pkg::ST_IDLE;
						fill_q     <= '0;
						overflow_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ia_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Register the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_strobe_q <= 1'b0;
		end else begin
			res_strobe_q <= busy;
		end
	end

	// Capture the head cell as it leaves the chain
	always_ff @(posedge clk) begin
		if (busy) begin
			res_key_q  <= cell_key[0];
			res_pos_q  <= cell_pos[0];
			res_last_q <= !cell_valid[1];
			res_ovf_q  <= overflow_q;
		end
	end

	assign result_strobe   = res_strobe_q;
	assign sorted_key      = res_key_q;
	assign origin_position = ia_pkg::OPOS_W'(res_pos_q);
	assign last_result     = res_last_q;
	assign overflowed      = res_ovf_q;

	// Occupied cells always form one run from the head
	`IA_ASSERT_IMP(a_valid_contig, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0)
	// Fill count matches occupancy while filling
	`IA_ASSERT_IMP(a_fill_match, !busy, $countones(valid_vec) == int'(fill_q))
	// Draining never starts from an empty chain
	`IA_ASSERT_IMP(a_drain_nonempty, busy, cell_valid[0])
	// The final result ends the run
	`IA_ASSERT_NXT(a_last_ends, result_strobe && last_result, !result_strobe)

endmodule

### tb/sv/tb.sv
// Self-checking testbench of the insertion argsort block: feeds sets of signed keys and
// checks every ranked word against a stable insertion sort kept in a scoreboard class.
// Depends on ia_pkg and the insertion_argsort top level.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEY_W    = ia_pkg::KEY_W;
	localparam int OPOS_W   = ia_pkg::OPOS_W;
	localparam int DEPTH    = ia_pkg::DEPTH_DEF;
	localparam int MAX_SHOW = 10;

	// One ranked word as it leaves the block
	typedef struct packed {
		logic signed [KEY_W-1:0] k;
		logic [OPOS_W-1:0]       pos;
		logic                    fin;
		logic                    ovf;
	} rank_t;

	// Stable insertion sort of the current set and the ranked words still owed
	class sort_board;
		logic signed [KEY_W-1:0] held_key [DEPTH];
		logic [OPOS_W-1:0]       held_pos [DEPTH];
		int                      held_count;
		bit                      dropped;
		rank_t                   ranked_q [$];
		int                      errors;

		function new();
			held_count = 0;
			dropped    = 0;
			errors     = 0;
		endfunction

		// Insert one accepted word; on the last word of a set, queue the whole ranking
		function void take_word(logic signed [KEY_W-1:0] k, logic fin);
			int    j;
			int    i;
			rank_t r;
			if (held_count < DEPTH) begin
				j = held_count;
				// shift up every stored key strictly greater, so ties keep arrival order
				while (j > 0 && held_key[j-1] > k) begin
					held_key[j] = held_key[j-1];
					held_pos[j] = held_pos[j-1];
					j--;
				end
				held_key[j] = k;
				held_pos[j] = OPOS_W'(held_count);
				held_count++;
			end else begin
				dropped = 1;
			end
			if (fin) begin
				for (i = 0; i < held_count; i++) begin
					r.k   = held_key[i];
					r.pos = held_pos[i];
					r.fin = (i + 1 == held_count);
					r.ovf = dropped;
					ranked_q.push_back(r);
				end
				held_count = 0;
				dropped    = 0;
			end
		endfunction

		// Compare one ranked word with the oldest one owed
		function void check_rank(logic signed [KEY_W-1:0] k, logic [OPOS_W-1:0] pos,
			logic fin, logic ovf);
			rank_t got;
			rank_t want;
			got = '{k: k, pos: pos, fin: fin, ovf: ovf};
			if (ranked_q.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOW)
					$display("unexpected word: key %0d pos %0d last %b ovf %b",
						k, pos, fin, ovf);
				return;
			end
			want = ranked_q.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= MAX_SHOW) begin
					$write("rank mismatch: want key %0d pos %0d last %b ovf %b, ",
						want.k, want.pos, want.fin, want.ovf);
					$display("got key %0d pos %0d last %b ovf %b", k, pos, fin, ovf);
				end
			end
		endfunction

		// Flag any words still owed
		function void close_out();
			if (ranked_q.size() != 0) begin
				errors += ranked_q.size();
				$display("%0d ranked words never arrived", ranked_q.size());
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic signed [KEY_W-1:0] key = '0;
	logic                    last_key = 1'b0;
	logic                    result_strobe;
	logic signed [KEY_W-1:0] sorted_key;
	logic [OPOS_W-1:0]       origin_position;
	logic                    last_result;
	logic                    overflowed;

	sort_board sb = new();
	bit        word_taken = 0;
	int        sent = 0;

	insertion_argsort dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.key             (key),
		.last_key        (last_key),
		.result_strobe   (result_strobe),
		.sorted_key      (sorted_key),
		.origin_position (origin_position),
		.last_result     (last_result),
		.overflowed      (overflowed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sample both channels at the rising edge; check results before noting a new word
	always @(posedge clk) begin
		if (!arst_n) begin
			word_taken = 0;
		end else begin
			if (result_strobe === 1'b1)
				sb.check_rank(sorted_key, origin_position, last_result, overflowed);
			word_taken = start && !busy;
			if (word_taken)
				sb.take_word(key, last_key);
		end
	end

	// Hold start low for a burst of cycles
	task automatic idle_for(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Present one word and hold it until the block takes it
	task automatic send_word(logic signed [KEY_W-1:0] k, logic fin);
		start    <= 1'b1;
		key      <= k;
		last_key <= fin;
		do @(negedge clk); while (!word_taken);
		sent++;
	endtask

	// Draw a key: full range, a narrow band full of ties, or extremes mixed in
	function automatic logic signed [KEY_W-1:0] pick_key(int mode);
		logic signed [KEY_W-1:0] k;
		case (mode)
			0: begin
				k = $urandom;
			end
			1: begin
				k = int'($urandom_range(0, 8)) - 4;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: k = 32'sh7fff_ffff;
					1: k = 32'sh8000_0000;
					2: k = int'($urandom_range(0, 2)) - 1;
					default: k = $urandom;
				endcase
			end
		endcase
		return k;
	endfunction

	// Send a set of len words, the last one marked
	task automatic send_set(int len, int mode, bit gaps);
		int i;
		for (i = 0; i < len; i++) begin
			if (gaps && $urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 19));
			send_word(pick_key(mode), i == len - 1);
		end
	endtask

	initial begin
		int i;
		int len;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// lone minimum key
		send_word(32'sh8000_0000, 1'b1);
		// extremes with a tie on -1
		send_word(32'sh7fff_ffff, 1'b0);
		send_word(-1, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(0, 1'b0);
		send_word(-1, 1'b1);
		// fill the store with descending pairs, then drop a marked last word
		for (i = 0; i < DEPTH + 1; i++)
			send_word(7 - i / 2, i == DEPTH);
		// next set starts clean after the overflow
		send_word(32'sh7fff_ffff, 1'b1);

		// random sets, mostly within capacity, some overflowing; no gaps near the end
		while (sent < 170) begin
			if ($urandom_range(0, 5) == 0)
				len = $urandom_range(DEPTH + 1, DEPTH + 4);
			else
				len = $urandom_range(1, DEPTH);
			send_set(len, $urandom_range(0, 2), sent < 130);
		end

		// drain and let the block settle
		start <= 1'b0;
		while (sb.ranked_q.size() != 0) @(negedge clk);
		repeat (DEPTH + 4) @(negedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Stop a hung run
	initial begin
		#400us;
		$display("status: fail");
		$finish;
	end

endmodule
